// ===== design/ukrtr_pkg.sv =====
// Package for the Ukrainian UTF-8 romanizer: byte codes, letter table and lookup.
// No dependencies; used by ukrainian_utf8_transliterator_core.
package ukrtr_pkg;

    localparam logic [7:0] BYTE_APOS  = 8'h27;
    localparam logic [7:0] LEAD_D0    = 8'hD0;
    localparam logic [7:0] LEAD_D1    = 8'hD1;
    localparam logic [7:0] LEAD_D2    = 8'hD2;
    localparam logic [7:0] LEAD_E2    = 8'hE2;
    localparam logic [7:0] CONT_80    = 8'h80;
    localparam logic [7:0] CONT_99    = 8'h99;
    localparam logic [31:0] UA_MASK   = 32'hD3FF_FFFF;

    localparam int MAX_OUT = 4;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // hit: the pair is a letter; len 0 means the letter is deleted.
    // str holds the ASCII text right aligned, first character highest.
    typedef struct packed {
        logic        hit;
        logic [2:0]  len;
        logic [31:0] str;
    } t_lkp;

    function automatic t_lkp mk(input logic [2:0] n, input logic [31:0] s);
        t_lkp r;
        r.hit = 1'b1;
        r.len = n;
        r.str = s;
        return r;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b == LEAD_D0) || (b == LEAD_D1) || (b == LEAD_D2) || (b == LEAD_E2);
    endfunction

    // Letter text for offset k from U+0410 (upper) or U+0430 (lower).
    function automatic t_lkp tab(input logic [4:0] k, input logic lower);
        t_lkp r;
        r = '0;
        case (k)
            5'd0:  r = mk(3'd1, "A");
            5'd1:  r = mk(3'd1, "B");
            5'd2:  r = mk(3'd1, "V");
            5'd3:  r = mk(3'd1, "H");
            5'd4:  r = mk(3'd1, "D");
            5'd5:  r = mk(3'd1, "E");
            5'd6:  r = mk(3'd2, "Zh");
            5'd7:  r = mk(3'd1, "Z");
            5'd8:  r = mk(3'd1, "Y");
            5'd9:  r = mk(3'd1, "Y");
            5'd10: r = mk(3'd1, "K");
            5'd11: r = mk(3'd1, "L");
            5'd12: r = mk(3'd1, "M");
            5'd13: r = mk(3'd1, "N");
            5'd14: r = mk(3'd1, "O");
            5'd15: r = mk(3'd1, "P");
            5'd16: r = mk(3'd1, "R");
            5'd17: r = mk(3'd1, "S");
            5'd18: r = mk(3'd1, "T");
            5'd19: r = mk(3'd1, "U");
            5'd20: r = mk(3'd1, "F");
            5'd21: r = mk(3'd2, "Kh");
            5'd22: r = mk(3'd2, "Ts");
            5'd23: r = mk(3'd2, "Ch");
            5'd24: r = mk(3'd2, "Sh");
            5'd25: r = mk(3'd4, "Shch");
            5'd30: r = mk(3'd2, "Yu");
            5'd31: r = mk(3'd2, "Ya");
            default: r = mk(3'd0, 32'h0);
        endcase
        if (lower) begin
            if (k == 5'd9) begin
                r = mk(3'd1, "i");
            end else if (k == 5'd30) begin
                r = mk(3'd2, "iu");
            end else if (k == 5'd31) begin
                r = mk(3'd2, "ia");
            end else if (r.len != 3'd0) begin
                // first character only goes to lower case
                r.str = r.str | (32'h20 << (8 * (int'(r.len) - 1)));
            end
        end
        return r;
    endfunction

    function automatic t_lkp ua_lookup(input logic [7:0] lead, input logic [7:0] b);
        t_lkp       r;
        logic [7:0] off;
        logic [4:0] k;
        logic       lower;
        logic       rng;
        r     = '0;
        off   = 8'(b - 8'h90);
        k     = '0;
        lower = 1'b0;
        rng   = 1'b0;
        if (lead == LEAD_D0) begin
            if (b >= 8'h90 && b <= 8'hAF) begin
                k   = off[4:0];
                rng = 1'b1;
            end else if (b >= 8'hB0 && b <= 8'hBF) begin
                k     = {1'b0, b[3:0]};
                lower = 1'b1;
                rng   = 1'b1;
            end else if (b == 8'h84) begin
                r = mk(3'd2, "Ye");
            end else if (b == 8'h86) begin
                r = mk(3'd1, "I");
            end else if (b == 8'h87) begin
                r = mk(3'd2, "Yi");
            end
        end else if (lead == LEAD_D1) begin
            if (b >= 8'h80 && b <= 8'h8F) begin
                k     = {1'b1, b[3:0]};
                lower = 1'b1;
                rng   = 1'b1;
            end else if (b == 8'h94) begin
                r = mk(3'd2, "ie");
            end else if (b == 8'h96 || b == 8'h97) begin
                r = mk(3'd1, "i");
            end
        end else if (lead == LEAD_D2) begin
            if (b == 8'h90) begin
                r = mk(3'd1, "G");
            end else if (b == 8'h91) begin
                r = mk(3'd1, "g");
            end
        end
        if (rng && UA_MASK[k]) begin
            r = tab(k, lower);
        end
        return r;
    endfunction

endpackage

// ===== design/ukrainian_utf8_transliterator_core.sv =====
// Ukrainian UTF-8 romanizer: byte stream in, ASCII/passed bytes out.
// Depends on ukrtr_pkg (byte codes, letter table, lookup function).
//
// Usage:
//   Input stream (s side): tdata carries one UTF-8 byte, tuser is the command
//   (0 = data byte, 1 = end of text: release held lead bytes unchanged).
//   Output stream (m side): tdata is one result byte, tlast marks the last
//   byte caused by one input transaction. An input that is deleted or only
//   held produces no output transaction.
//   The result is registered and appears in the cycle after the input transaction.
//   Throughput: one input per cycle while each input yields at most one byte
//   and the receiver takes each byte; an input yielding N bytes (up to 4, for
//   the Shch letter) holds the single output job register until all are taken.
//   The hold state (count plus a two-entry lead-byte store) is read and
//   written back in the accepting cycle, so consecutive bytes need no stall.
//   Reset clears the hold count and the output job; nothing is held.
//   When the receiver stalls, the current result byte stays on the port and
//   o_s_tready stays low until the last byte of the job is taken.
module ukrainian_utf8_transliterator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] cmd
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);
    import ukrtr_pkg::*;

    // hold state
    logic [1:0] r_held_cnt, n_held_cnt;
    logic [7:0] r_held [2];
    logic       wr0_en, wr1_en;

    // output job
    logic [7:0] r_job [MAX_OUT];
    logic [2:0] r_rem;
    logic [1:0] r_idx;

    logic [7:0] em [MAX_OUT];
    logic [2:0] em_n;
    logic       s_acc, m_acc;

    assign o_m_tvalid = (r_rem != 3'd0);
    assign o_m_tlast  = (r_rem == 3'd1);
    assign o_m_tdata  = r_job[r_idx];
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_rem == 3'd0) || (r_rem == 3'd1 && i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        t_lkp lk;
        logic fresh;
        logic [7:0] b;
        b          = i_s_tdata;
        lk         = ua_lookup(r_held[0], b);
        fresh      = 1'b0;
        em_n       = 3'd0;
        wr0_en     = 1'b0;
        wr1_en     = 1'b0;
        n_held_cnt = 2'd0;
        for (int i = 0; i < MAX_OUT; i++) begin
            em[i] = 8'h00;
        end
        if (i_s_tuser == CMD_FLUSH) begin
            if (r_held_cnt != 2'd0) begin
                em[0] = r_held[0];
                em_n  = 3'd1;
            end
            if (r_held_cnt[1]) begin
                em[1] = r_held[1];
                em_n  = 3'd2;
            end
        end else if (r_held_cnt == 2'd0) begin
            fresh = 1'b1;
        end else if (r_held_cnt == 2'd1) begin
            if (r_held[0] == LEAD_E2) begin
                if (b == CONT_80) begin
                    wr1_en     = 1'b1;
                    n_held_cnt = 2'd2;
                end else begin
                    em[0] = r_held[0];
                    em_n  = 3'd1;
                    fresh = 1'b1;
                end
            end else if (lk.hit) begin
                for (int i = 0; i < MAX_OUT; i++) begin
                    if (i < int'(lk.len)) begin
                        em[i] = 8'(lk.str >> (8 * (int'(lk.len) - 1 - i)));
                    end
                end
                em_n = lk.len;
            end else begin
                em[0] = r_held[0];
                em_n  = 3'd1;
                fresh = 1'b1;
            end
        end else begin
            // two held (E2 80): only 99 completes the deleted right quote
            if (b != CONT_99) begin
                em[0] = r_held[0];
                em[1] = r_held[1];
                em_n  = 3'd2;
                fresh = 1'b1;
            end
        end
        if (fresh) begin
            if (is_lead(b)) begin
                wr0_en     = 1'b1;
                n_held_cnt = 2'd1;
            end else if (b != BYTE_APOS) begin
                em[em_n[1:0]] = b;
                em_n          = 3'(em_n + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_rem      <= 3'd0;
            r_idx      <= 2'd0;
        end else begin
            if (s_acc) begin
                r_held_cnt <= n_held_cnt;
            end
            if (s_acc && em_n != 3'd0) begin
                r_rem <= em_n;
                r_idx <= 2'd0;
            end else if (m_acc) begin
                r_rem <= 3'(r_rem - 3'd1);
                r_idx <= 2'(r_idx + 2'd1);
            end
        end
    end

    // lead-byte store and job bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_acc && wr0_en) begin
            r_held[0] <= i_s_tdata;
        end
        if (s_acc && wr1_en) begin
            r_held[1] <= i_s_tdata;
        end
        if (s_acc && em_n != 3'd0) begin
            for (int i = 0; i < MAX_OUT; i++) begin
                r_job[i] <= em[i];
            end
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("hold count out of range");

    a_rem_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd4 && (32'(r_idx) + 32'(r_rem)) <= 32'd4)
        else $error("job index/remaining out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem > 3'd1) |-> !o_s_tready)
        else $error("input accepted while job has more than one byte left");

    a_job_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && !s_acc && r_rem > 3'd1) |=> (r_rem == $past(r_rem) - 3'd1))
        else $error("job count did not step down on output transaction");

endmodule
